// ----- hw/rtl/pl0ts_pkg.sv -----
// Package with types, symbol numbers and keyword matching for the PL/0 token scanner.
package pl0ts_pkg;

    localparam int IDENT_MAX_CHARS_DEF   = 11;
    localparam int NUMBER_MAX_DIGITS_DEF = 5;
    localparam int NAME_STORE            = 11;

    localparam logic [2:0] ST_TOKEN     = 3'd0;
    localparam logic [2:0] ST_IDENT_LONG = 3'd1;
    localparam logic [2:0] ST_NUM_LONG  = 3'd2;
    localparam logic [2:0] ST_LETTER_NUM = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;

    localparam logic [5:0] SYM_IDENT  = 6'd2;
    localparam logic [5:0] SYM_NUMBER = 6'd3;
    localparam logic [5:0] SYM_PLUS   = 6'd4;
    localparam logic [5:0] SYM_MINUS  = 6'd5;
    localparam logic [5:0] SYM_TIMES  = 6'd6;
    localparam logic [5:0] SYM_SLASH  = 6'd7;
    localparam logic [5:0] SYM_EQL    = 6'd9;
    localparam logic [5:0] SYM_NEQ    = 6'd10;
    localparam logic [5:0] SYM_LSS    = 6'd11;
    localparam logic [5:0] SYM_LEQ    = 6'd12;
    localparam logic [5:0] SYM_GTR    = 6'd13;
    localparam logic [5:0] SYM_GEQ    = 6'd14;
    localparam logic [5:0] SYM_LPAREN = 6'd15;
    localparam logic [5:0] SYM_RPAREN = 6'd16;
    localparam logic [5:0] SYM_COMMA  = 6'd17;
    localparam logic [5:0] SYM_SEMI   = 6'd18;
    localparam logic [5:0] SYM_PERIOD = 6'd19;
    localparam logic [5:0] SYM_BECOMES = 6'd20;
    localparam logic [5:0] SYM_BEGIN  = 6'd21;
    localparam logic [5:0] SYM_END    = 6'd22;
    localparam logic [5:0] SYM_IF     = 6'd23;
    localparam logic [5:0] SYM_THEN   = 6'd24;
    localparam logic [5:0] SYM_WHILE  = 6'd25;
    localparam logic [5:0] SYM_DO     = 6'd26;
    localparam logic [5:0] SYM_CALL   = 6'd27;
    localparam logic [5:0] SYM_CONST  = 6'd28;
    localparam logic [5:0] SYM_VAR    = 6'd29;
    localparam logic [5:0] SYM_PROC   = 6'd30;
    localparam logic [5:0] SYM_WRITE  = 6'd31;
    localparam logic [5:0] SYM_READ   = 6'd32;
    localparam logic [5:0] SYM_ELSE   = 6'd33;
    localparam logic [5:0] SYM_NONE   = 6'd0;

    typedef enum logic [10:0] {
        M_IDLE       = 11'b000_0000_0001,
        M_IDENT      = 11'b000_0000_0010,
        M_NUM        = 11'b000_0000_0100,
        M_LT         = 11'b000_0000_1000,
        M_GT         = 11'b000_0001_0000,
        M_COLON      = 11'b000_0010_0000,
        M_SLASH      = 11'b000_0100_0000,
        M_BLOCK      = 11'b000_1000_0000,
        M_BLOCK_STAR = 11'b001_0000_0000,
        M_LINE       = 11'b010_0000_0000,
        M_ERROR      = 11'b100_0000_0000
    } t_mode;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  token_type;
        logic [16:0] number_value;
        logic [63:0] name_low;
        logic [23:0] name_high;
        logic [3:0]  name_length;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } t_item;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic t_result tok(input logic [5:0] t);
        t_result r;
        r = '0;
        r.token_type = t;
        return r;
    endfunction

    function automatic t_result err(input logic [2:0] s);
        t_result r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    // Keyword lookup over the packed name; returns zero when no keyword matches.
    function automatic logic [5:0] keyword_sym(input logic [87:0] nm, input logic [3:0] len);
        logic [5:0] s;
        s = SYM_NONE;
        case (len)
            4'd2: begin
                if (nm[15:0] == "fi") s = SYM_IF;
                else if (nm[15:0] == "od") s = SYM_DO;
            end
            4'd3: begin
                if (nm[23:0] == "dne") s = SYM_END;
                else if (nm[23:0] == "rav") s = SYM_VAR;
            end
            4'd4: begin
                if (nm[31:0] == "neht") s = SYM_THEN;
                else if (nm[31:0] == "llac") s = SYM_CALL;
                else if (nm[31:0] == "daer") s = SYM_READ;
                else if (nm[31:0] == "esle") s = SYM_ELSE;
            end
            4'd5: begin
                if (nm[39:0] == "nigeb") s = SYM_BEGIN;
                else if (nm[39:0] == "elihw") s = SYM_WHILE;
                else if (nm[39:0] == "tsnoc") s = SYM_CONST;
                else if (nm[39:0] == "etirw") s = SYM_WRITE;
            end
            4'd9: begin
                if (nm[71:0] == "erudecorp") s = SYM_PROC;
            end
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/pl0ts_if.sv -----
// Valid/ready channel interface carrying one payload per transaction.
interface pl0ts_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pl0ts_out_queue.sv -----
// Two-entry result queue that decouples the scanner from the output channel.
module pl0ts_out_queue import pl0ts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_push2,
    input  t_result i_res0,
    input  t_result i_res1,
    output logic    o_empty,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop
);
    t_result    r_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] w_rem;

    assign o_valid = r_cnt != 2'd0;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_q[0];
    assign w_rem   = r_cnt - {1'b0, i_pop};
    assign n_cnt   = w_rem + (i_push ? (i_push2 ? 2'd2 : 2'd1) : 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && w_rem == 2'd0) begin
            r_q[0] <= i_res0;
            r_q[1] <= i_res1;
        end else begin
            if (i_pop) begin
                r_q[0] <= r_q[1];
            end
            if (i_push) begin
                r_q[1] <= i_res0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (w_rem == 2'd0 || (w_rem == 2'd1 && !i_push2)))
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("result queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");
`endif
endmodule

// ----- hw/rtl/pl0_token_scanner_unit.sv -----
// Top level of the PL/0 token scanner: scan state, token formation and channels.
// Each byte is held in the input register, and its results in the output queue.
// One byte per cycle if not stalled; a byte with two results waits for an empty queue.
// The output queue holds two results, so input also waits while the sink stalls.
// Reset is synchronous and active low; it returns the scanner to idle and empties the queue.
// The stored name characters are not cleared by reset.
module pl0_token_scanner_unit import pl0ts_pkg::*; #(
    parameter int IDENT_MAX_CHARS   = IDENT_MAX_CHARS_DEF,
    parameter int NUMBER_MAX_DIGITS = NUMBER_MAX_DIGITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    pl0ts_if.sink   in_ch,
    pl0ts_if.source out_ch
);
    t_mode       r_mode, n_mode;
    logic [7:0]  r_name [NAME_STORE];
    logic [3:0]  r_cnt, n_cnt;
    logic [16:0] r_val, n_val;
    logic [2:0]  r_dig, n_dig;
    logic        r_iv;
    t_item       r_in;
    t_result     w_res [2];
    logic [1:0]  w_n;
    logic        w_wr;
    logic [3:0]  w_wa;
    logic        w_empty;
    logic        w_qvalid;
    logic        w_take;
    logic [87:0] w_nm;
    t_result     w_ident;
    logic [5:0]  w_kw;
    logic [7:0]  c;
    logic        eos;
    logic        w_stall;

    // Input register is taken when empty or when its item moves on this cycle.
    assign w_stall     = r_iv && !w_empty && !(w_qvalid && out_ch.ready && w_n != 2'd2);
    assign in_ch.ready = !w_stall;
    assign w_take      = r_iv && !w_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (in_ch.ready) begin
            r_iv <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) begin
            r_in <= in_ch.data;
        end
    end

    assign c   = r_in.source_byte;
    assign eos = r_in.end_of_source;

    always_comb begin
        w_nm = '0;
        for (int i = 0; i < NAME_STORE; i++) begin
            if (4'(i) < r_cnt) begin
                w_nm[8*i +: 8] = r_name[i];
            end
        end
    end

    assign w_kw = keyword_sym(w_nm, r_cnt);

    always_comb begin
        w_ident = tok(w_kw);
        if (w_kw == SYM_NONE) begin
            w_ident.token_type  = SYM_IDENT;
            w_ident.name_low    = w_nm[63:0];
            w_ident.name_high   = w_nm[87:64];
            w_ident.name_length = r_cnt;
        end
    end

    always_comb begin
        t_mode   m;
        logic    start;
        logic    pend_num_ok;
        t_result num_res;
        m = r_mode;
        start = 1'b0;
        n_cnt = r_cnt;
        n_val = r_val;
        n_dig = r_dig;
        w_wr = 1'b0;
        w_wa = 4'd0;
        w_n = 2'd0;
        w_res[0] = '0;
        w_res[1] = '0;
        num_res = tok(SYM_NUMBER);
        num_res.number_value = r_val;
        pend_num_ok = r_dig <= 3'(NUMBER_MAX_DIGITS);
        case (r_mode)
            M_IDENT: begin
                if (is_letter(c) || is_digit(c)) begin
                    if (r_cnt >= 4'(IDENT_MAX_CHARS)) begin
                        w_res[0] = err(ST_IDENT_LONG);
                        w_n = 2'd1;
                        m = M_ERROR;
                    end else begin
                        w_wr = 1'b1;
                        w_wa = r_cnt;
                        n_cnt = r_cnt + 4'd1;
                    end
                end else begin
                    w_res[0] = w_ident;
                    w_n = 2'd1;
                    start = 1'b1;
                end
            end
            M_NUM: begin
                if (is_digit(c)) begin
                    if (r_dig < 3'(NUMBER_MAX_DIGITS)) begin
                        n_val = 17'((r_val << 3) + (r_val << 1) + 17'(c - 8'h30));
                        n_dig = r_dig + 3'd1;
                    end else begin
                        n_dig = 3'(NUMBER_MAX_DIGITS + 1);
                    end
                end else if (is_letter(c)) begin
                    w_res[0] = err(ST_LETTER_NUM);
                    w_n = 2'd1;
                    m = M_ERROR;
                end else if (!pend_num_ok) begin
                    w_res[0] = err(ST_NUM_LONG);
                    w_n = 2'd1;
                    m = M_ERROR;
                end else begin
                    w_res[0] = num_res;
                    w_n = 2'd1;
                    start = 1'b1;
                end
            end
            M_LT: begin
                if (c == "=") begin
                    w_res[0] = tok(SYM_LEQ); w_n = 2'd1; m = M_IDLE;
                end else if (c == ">") begin
                    w_res[0] = tok(SYM_NEQ); w_n = 2'd1; m = M_IDLE;
                end else begin
                    w_res[0] = tok(SYM_LSS); w_n = 2'd1; start = 1'b1;
                end
            end
            M_GT: begin
                if (c == "=") begin
                    w_res[0] = tok(SYM_GEQ); w_n = 2'd1; m = M_IDLE;
                end else begin
                    w_res[0] = tok(SYM_GTR); w_n = 2'd1; start = 1'b1;
                end
            end
            M_COLON: begin
                w_n = 2'd1;
                if (c == "=") begin
                    w_res[0] = tok(SYM_BECOMES); m = M_IDLE;
                end else begin
                    w_res[0] = err(ST_INVALID); m = M_ERROR;
                end
            end
            M_SLASH: begin
                if (c == "*") begin
                    m = M_BLOCK;
                end else if (c == "/") begin
                    m = M_LINE;
                end else begin
                    w_res[0] = tok(SYM_SLASH); w_n = 2'd1; start = 1'b1;
                end
            end
            M_BLOCK: begin
                if (c == "*") m = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
                if (c == "/") m = M_IDLE;
                else if (c != "*") m = M_BLOCK;
            end
            M_LINE: begin
                if (c == 8'h0a) m = M_IDLE;
            end
            M_ERROR: begin
                m = M_ERROR;
            end
            default: start = 1'b1;
        endcase

        if (start) begin
            t_result sr;
            logic    emit;
            sr = '0;
            emit = 1'b0;
            m = M_IDLE;
            if (is_letter(c)) begin
                m = M_IDENT;
                w_wr = 1'b1;
                w_wa = 4'd0;
                n_cnt = 4'd1;
            end else if (is_digit(c)) begin
                m = M_NUM;
                n_val = 17'(c - 8'h30);
                n_dig = 3'd1;
            end else if (!is_space(c)) begin
                emit = 1'b1;
                case (c)
                    "<": begin m = M_LT; emit = 1'b0; end
                    ">": begin m = M_GT; emit = 1'b0; end
                    ":": begin m = M_COLON; emit = 1'b0; end
                    "/": begin m = M_SLASH; emit = 1'b0; end
                    "+": sr = tok(SYM_PLUS);
                    "-": sr = tok(SYM_MINUS);
                    "*": sr = tok(SYM_TIMES);
                    "=": sr = tok(SYM_EQL);
                    "(": sr = tok(SYM_LPAREN);
                    ")": sr = tok(SYM_RPAREN);
                    ",": sr = tok(SYM_COMMA);
                    ";": sr = tok(SYM_SEMI);
                    ".": sr = tok(SYM_PERIOD);
                    default: begin sr = err(ST_INVALID); m = M_ERROR; end
                endcase
            end
            if (emit) begin
                w_res[w_n[0]] = sr;
                w_n = w_n + 2'd1;
            end
        end

        // End of source flushes the pending token; the mode seen is the one just formed.
        if (eos) begin
            t_result     fr;
            logic        fl;
            logic [87:0] fnm;
            logic [5:0]  fkw;
            fr = '0;
            fl = 1'b1;
            fnm = '0;
            fkw = SYM_NONE;
            case (m)
                M_IDENT: begin
                    // The name includes the character written this cycle.
                    fnm = w_nm;
                    if (n_cnt == 4'd1) begin
                        fnm = {80'd0, c};
                    end else if (w_wr) begin
                        fnm[{r_cnt, 3'b000} +: 8] = c;
                    end
                    fkw = keyword_sym(fnm, n_cnt);
                    fr = tok(fkw);
                    if (fkw == SYM_NONE) begin
                        fr.token_type  = SYM_IDENT;
                        fr.name_low    = fnm[63:0];
                        fr.name_high   = fnm[87:64];
                        fr.name_length = n_cnt;
                    end
                end
                M_NUM: begin
                    if (n_dig > 3'(NUMBER_MAX_DIGITS)) begin
                        fr = err(ST_NUM_LONG);
                    end else begin
                        fr = tok(SYM_NUMBER);
                        fr.number_value = n_val;
                    end
                end
                M_LT:    fr = tok(SYM_LSS);
                M_GT:    fr = tok(SYM_GTR);
                M_COLON: fr = err(ST_INVALID);
                M_SLASH: fr = tok(SYM_SLASH);
                default: fl = 1'b0;
            endcase
            if (fl && w_n != 2'd2) begin
                w_res[w_n[0]] = fr;
                w_n = w_n + 2'd1;
            end
            m = M_IDLE;
            n_cnt = 4'd0;
            n_val = '0;
            n_dig = '0;
        end
        if (w_n == 2'd1) w_res[0].last_of_run = 1'b1;
        if (w_n == 2'd2) w_res[1].last_of_run = 1'b1;
        n_mode = m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cnt  <= 4'd0;
            r_val  <= '0;
            r_dig  <= '0;
        end else if (w_take) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_val  <= n_val;
            r_dig  <= n_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_wr) begin
            r_name[w_wa] <= c;
        end
    end

    pl0ts_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take && w_n != 2'd0),
        .i_push2 (w_n == 2'd2),
        .i_res0  (w_res[0]),
        .i_res1  (w_res[1]),
        .o_empty (w_empty),
        .o_valid (w_qvalid),
        .o_data  (out_ch.data),
        .i_pop   (out_ch.valid && out_ch.ready)
    );
    assign out_ch.valid = w_qvalid;

`ifndef SYNTHESIS
    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("scan mode not one-hot");
    a_eos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && eos) |=> (r_mode == M_IDLE && r_cnt == 4'd0))
        else $error("end of source did not return to idle");
    a_ident_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(IDENT_MAX_CHARS))
        else $error("identifier length beyond limit");
`endif
endmodule
